// File: rtl/jse_pkg.sv
// Package for the JSON string escaper: byte codes, item type, lookup functions.
`default_nettype none

package jse_pkg;

  // Largest run of bytes one code unit can produce: quote, six escape bytes, quote
  localparam int unsigned MaxBytes = 8;
  localparam int unsigned IdxW     = $clog2(MaxBytes);
  localparam int unsigned CntW     = $clog2(MaxBytes + 1);

  // ASCII codes used by the escaper
  localparam logic [7:0] ChQuote     = 8'h22;
  localparam logic [7:0] ChBackslash = 8'h5c;
  localparam logic [7:0] ChLowerU    = 8'h75;

  // Printable range bounds and control-letter range
  localparam logic [15:0] PrintLow  = 16'd31;
  localparam logic [15:0] PrintHigh = 16'd127;
  localparam logic [15:0] CtlLow    = 16'd7;
  localparam logic [15:0] CtlHigh   = 16'd13;

  // One expanded item: its bytes in order and how many are valid
  typedef struct packed {
    logic [MaxBytes-1:0][7:0] bytes;
    logic [CntW-1:0]          count;
  } jse_item_t;

  // Lowercase hex digit for a nibble
  function automatic logic [7:0] hex_digit(input logic [3:0] nib);
    logic [7:0] res;
    if (nib < 4'd10) begin
      res = 8'h30 + {4'h0, nib};
    end else begin
      res = 8'h57 + {4'h0, nib};
    end
    return res;
  endfunction

  // Escape letter for control codes 7 to 13
  function automatic logic [7:0] ctl_letter(input logic [3:0] code);
    logic [7:0] res;
    unique case (code)
      4'd7:    res = 8'h61; // a
      4'd8:    res = 8'h62; // b
      4'd9:    res = 8'h74; // t
      4'd10:   res = 8'h6e; // n
      4'd11:   res = 8'h76; // v
      4'd12:   res = 8'h66; // f
      4'd13:   res = 8'h72; // r
      default: res = 8'h3f;
    endcase
    return res;
  endfunction

endpackage

`default_nettype wire

// File: rtl/jse_in_if.sv
// Input channel: one UTF-16 code unit with framing flags.
`default_nettype none

interface jse_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] code_unit;
  logic        is_first;
  logic        is_last;
  logic        no_char;

  modport source (output valid, output code_unit, output is_first, output is_last,
                  output no_char, input ready);
  modport sink (input valid, input code_unit, input is_first, input is_last,
                input no_char, output ready);
endinterface

`default_nettype wire

// File: rtl/jse_out_if.sv
// Output channel: one byte of the escaped string per transfer.
`default_nettype none

interface jse_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       run_end;

  modport source (output valid, output out_byte, output run_end, input ready);
  modport sink (input valid, input out_byte, input run_end, output ready);
endinterface

`default_nettype wire

// File: rtl/jse_encoder.sv
// Expands one code unit and its framing flags into the full run of output bytes.
`default_nettype none

module jse_encoder
  import jse_pkg::*;
(
  input  logic [15:0] code_unit_i,
  input  logic        is_first_i,
  input  logic        is_last_i,
  input  logic        no_char_i,
  output jse_item_t   item_o
);

  logic [MaxBytes-1:0][7:0] ch;
  logic [IdxW-1:0]          ch_n;
  logic [CntW-1:0]          j;

  // Encode the character itself
  always_comb begin
    ch   = '0;
    ch_n = '0;
    if (!no_char_i) begin
      priority if (code_unit_i > PrintLow && code_unit_i < PrintHigh) begin
        if (code_unit_i[7:0] == ChBackslash || code_unit_i[7:0] == ChQuote) begin
          ch[0] = ChBackslash;
          ch[1] = code_unit_i[7:0];
          ch_n  = IdxW'(2);
        end else begin
          ch[0] = code_unit_i[7:0];
          ch_n  = IdxW'(1);
        end
      end else if (code_unit_i >= CtlLow && code_unit_i <= CtlHigh) begin
        ch[0] = ChBackslash;
        ch[1] = ctl_letter(code_unit_i[3:0]);
        ch_n  = IdxW'(2);
      end else begin
        ch[0] = ChBackslash;
        ch[1] = ChLowerU;
        ch[2] = hex_digit(code_unit_i[15:12]);
        ch[3] = hex_digit(code_unit_i[11:8]);
        ch[4] = hex_digit(code_unit_i[7:4]);
        ch[5] = hex_digit(code_unit_i[3:0]);
        ch_n  = IdxW'(6);
      end
    end
  end

  // Place opening quote, character bytes and closing quote
  always_comb begin
    j = '0;
    for (int k = 0; k < MaxBytes; k++) begin
      j = CntW'(k) - CntW'(is_first_i);
      if (is_first_i && k == 0) begin
        item_o.bytes[k] = ChQuote;
      end else if (j < CntW'(ch_n)) begin
        item_o.bytes[k] = ch[j[IdxW-1:0]];
      end else begin
        item_o.bytes[k] = ChQuote;
      end
    end
    item_o.count = CntW'(is_first_i) + CntW'(ch_n) + CntW'(is_last_i);
  end

endmodule

`default_nettype wire

// File: rtl/json_string_escaper_top.sv
// Top level of the JSON string escaper: item register, byte serializer, output register.
//
//   channel | dir | payload                                   | handshake
//   in_i    | in  | code_unit[16] is_first is_last no_char    | valid/ready
//   out_o   | out | out_byte[8] run_end                       | valid/ready
//
// One byte leaves per cycle while the output is not stalled; an item yields 0 to 8 bytes
// (1 for plain ASCII, 6 for a \u escape), and the byte serializer sets the rate.
// A new item is taken in the cycle its predecessor's last byte enters the output
// register, so items follow back to back. An item that yields no bytes is taken but sends nothing.
// Reset clears the byte count and the output valid; no clearing pass is needed.
// A stalled output holds its byte; the serializer keeps the rest meanwhile.
`default_nettype none

module json_string_escaper_top
  import jse_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  jse_in_if.sink        in_i,
  jse_out_if.source     out_o
);

  jse_item_t                enc_item;
  logic [MaxBytes-1:0][7:0] buf_q;
  logic [CntW-1:0]          rem_q;
  logic [IdxW-1:0]          idx_q;
  logic                     out_valid_q;
  logic [7:0]               out_byte_q;
  logic                     run_end_q;
  logic                     out_load;
  logic                     in_xfer;

  jse_encoder u_encoder (
    .code_unit_i (in_i.code_unit),
    .is_first_i  (in_i.is_first),
    .is_last_i   (in_i.is_last),
    .no_char_i   (in_i.no_char),
    .item_o      (enc_item)
  );

  // Move a byte into the output register when it is empty or being drained
  assign out_load   = (rem_q != '0) && (!out_valid_q || out_o.ready);
  assign in_i.ready = (rem_q == '0) || (rem_q == CntW'(1) && out_load);
  assign in_xfer    = in_i.valid && in_i.ready;

  // Serializer control: load a new run or advance through the current one
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q <= '0;
      idx_q <= '0;
    end else if (in_xfer) begin
      rem_q <= enc_item.count;
      idx_q <= '0;
    end else if (out_load) begin
      rem_q <= rem_q - CntW'(1);
      idx_q <= idx_q + IdxW'(1);
    end
  end

  // Hold the expanded bytes of the current item
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      buf_q <= enc_item.bytes;
    end
  end

  // Output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  // Output payload
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_byte_q <= buf_q[idx_q];
      run_end_q  <= (rem_q == CntW'(1));
    end
  end

  assign out_o.valid    = out_valid_q;
  assign out_o.out_byte = out_byte_q;
  assign out_o.run_end  = run_end_q;

endmodule

`default_nettype wire

// File: test/tb_json_string_escaper_top.sv
// Testbench for the JSON string escaper: directed and random UTF-16 strings, checked per byte.
`timescale 1ns / 100ps

module tb_json_string_escaper_top;
  import jse_pkg::*;

  // One expected output byte and its end-of-run flag
  typedef struct {
    logic [7:0] data;
    logic       run_end;
  } esc_byte_t;

  logic clk = 1'b0;
  logic rst_n;

  jse_in_if  in_ch ();
  jse_out_if out_ch ();

  json_string_escaper_top dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  esc_byte_t pending_bytes [$];
  int        err_count    = 0;
  bit        idle_en      = 1'b1;
  int        rx_hold_req  = 0;
  int        rx_hold_left = 0;
  int        rx_wait      = 0;

  // Run the clock at a 4 ns period
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Print one mismatch line and count it
  task automatic report_mismatch(input string msg);
    $display("%0t ns: mismatch: %s", $time, msg);
    err_count++;
  endtask

  // Compute the escaped bytes of one item and queue them
  function automatic void predict_escape(input logic [15:0] cu, input logic first,
                                         input logic last, input logic none);
    logic [7:0] seq [8];
    logic [3:0] nib;
    esc_byte_t  eb;
    int         n;
    n = 0;
    if (first) begin
      seq[n] = ChQuote;
      n++;
    end
    if (!none) begin
      if (cu > PrintLow && cu < PrintHigh) begin
        // Printable: prefix quote and backslash with a backslash
        if (cu[7:0] == ChBackslash || cu[7:0] == ChQuote) begin
          seq[n] = ChBackslash;
          n++;
        end
        seq[n] = cu[7:0];
        n++;
      end else if (cu >= CtlLow && cu <= CtlHigh) begin
        // Control codes with a letter escape, bell and vertical tab included
        seq[n] = ChBackslash;
        n++;
        case (cu[3:0])
          4'd7:    seq[n] = "a";
          4'd8:    seq[n] = "b";
          4'd9:    seq[n] = "t";
          4'd10:   seq[n] = "n";
          4'd11:   seq[n] = "v";
          4'd12:   seq[n] = "f";
          default: seq[n] = "r";
        endcase
        n++;
      end else begin
        // Everything else as \u and four lowercase hex digits
        seq[n] = ChBackslash;
        seq[n+1] = ChLowerU;
        n += 2;
        for (int k = 3; k >= 0; k--) begin
          nib = cu[4*k +: 4];
          seq[n] = (nib < 4'd10) ? ("0" + {4'h0, nib}) : ("a" - 8'd10 + {4'h0, nib});
          n++;
        end
      end
    end
    if (last) begin
      seq[n] = ChQuote;
      n++;
    end
    for (int k = 0; k < n; k++) begin
      eb.data    = seq[k];
      eb.run_end = (k == n - 1);
      pending_bytes.push_back(eb);
    end
  endfunction

  // Offer one item after a random gap, hold it until the transfer, then predict it
  task automatic send_unit(input logic [15:0] cu, input logic first, input logic last,
                           input logic none);
    int gap;
    gap = idle_en ? $urandom_range(0, 6) : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.code_unit <= cu;
    in_ch.is_first  <= first;
    in_ch.is_last   <= last;
    in_ch.no_char   <= none;
    do @(posedge clk); while (!in_ch.ready);
    predict_escape(cu, first, last, none);
  endtask

  // Draw a code unit biased toward the interesting classes
  function automatic logic [15:0] pick_unit();
    logic [15:0] cu;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: cu = 16'($urandom_range(32, 126));
      5:             cu = 16'($urandom_range(7, 13));
      6:             cu = $urandom_range(0, 1) ? 16'(ChQuote) : 16'(ChBackslash);
      7:             cu = 16'($urandom_range(0, 31));
      default:       cu = 16'($urandom);
    endcase
    return cu;
  endfunction

  // Character classes: printable bounds, escaped printables, control letters, \u cases
  task automatic test_escapes();
    logic [15:0] codes [$];
    codes = '{16'd32, 16'd126, 16'(ChBackslash), 16'(ChQuote), 16'd31, 16'd127,
              16'h0000, 16'hffff, 16'd7, 16'd8, 16'd9, 16'd10, 16'd11, 16'd12, 16'd13,
              16'd6, 16'd14, 16'hd800, 16'hdfff};
    foreach (codes[i]) send_unit(codes[i], 1'b0, 1'b0, 1'b0);
  endtask

  // Framing flags: empty string, silent item, quotes alone, one-character string
  task automatic test_framing();
    send_unit(16'h1234, 1'b1, 1'b1, 1'b1);
    send_unit(16'hffff, 1'b0, 1'b0, 1'b1);
    send_unit(16'h0041, 1'b1, 1'b0, 1'b1);
    send_unit(16'h0000, 1'b0, 1'b1, 1'b1);
    send_unit(16'h0000, 1'b1, 1'b1, 1'b0);
  endtask

  // Well-formed strings with random content and occasional empty units
  task automatic test_random_strings(input int n_strings);
    int len;
    for (int s = 0; s < n_strings; s++) begin
      idle_en = ($urandom_range(0, 3) != 0);
      len = $urandom_range(0, 6);
      if (len == 0) begin
        send_unit(16'($urandom), 1'b1, 1'b1, 1'b1);
      end else begin
        for (int i = 0; i < len; i++) begin
          send_unit(pick_unit(), i == 0, i == len - 1, $urandom_range(0, 9) == 0);
        end
      end
    end
    idle_en = 1'b1;
  endtask

  // Unstructured items: every flag and code bit at random
  task automatic test_random_noise(input int n_items);
    for (int i = 0; i < n_items; i++) begin
      send_unit(16'($urandom), 1'($urandom), 1'($urandom), 1'($urandom));
    end
  endtask

  // Hold the output off for a long stretch while long escapes keep arriving
  task automatic test_backpressure(input int n_items);
    idle_en     = 1'b0;
    rx_hold_req = 300;
    for (int i = 0; i < n_items; i++) begin
      send_unit(16'($urandom_range(256, 65535)), (i % 5) == 0, (i % 5) == 4, 1'b0);
    end
    idle_en = 1'b1;
  endtask

  // Receiver: random stall after each transfer, plus requested long hold-offs
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rx_hold_req > 0) begin
        rx_hold_left = rx_hold_req;
        rx_hold_req  = 0;
      end
      if (rx_hold_left > 0) begin
        rx_hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        if (out_ch.valid && out_ch.ready) begin
          rx_wait = idle_en ? $urandom_range(0, 6) : 0;
        end else if (rx_wait > 0) begin
          rx_wait--;
        end
        out_ch.ready <= (rx_wait == 0);
      end
    end
  end

  // Compare each output transfer with the oldest expected byte
  always @(posedge clk) begin
    esc_byte_t eb;
    if (rst_n === 1'b1 && out_ch.valid && out_ch.ready) begin
      if (pending_bytes.size() == 0) begin
        report_mismatch($sformatf("unexpected byte %h run_end %b",
                                  out_ch.out_byte, out_ch.run_end));
      end else begin
        eb = pending_bytes.pop_front();
        if (out_ch.out_byte !== eb.data) begin
          report_mismatch($sformatf("out_byte %h, expected %h", out_ch.out_byte, eb.data));
        end
        if (out_ch.run_end !== eb.run_end) begin
          report_mismatch($sformatf("run_end %b, expected %b on byte %h",
                                    out_ch.run_end, eb.run_end, eb.data));
        end
      end
    end
  end

  // Main sequence: reset, tests in turn, drain, verdict
  initial begin
    rst_n           <= 1'b0;
    in_ch.valid     <= 1'b0;
    in_ch.code_unit <= '0;
    in_ch.is_first  <= 1'b0;
    in_ch.is_last   <= 1'b0;
    in_ch.no_char   <= 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_escapes();
    test_framing();
    test_random_strings(80);
    test_random_noise(70);
    test_backpressure(40);
    test_random_strings(10);
    in_ch.valid <= 1'b0;
    while (pending_bytes.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (err_count == 0) begin
      $display("tb_json_string_escaper_top: clean");
    end else begin
      $display("tb_json_string_escaper_top: errors");
    end
    $finish;
  end

  // Watchdog far beyond the slowest correct run
  initial begin
    #2000000;
    $display("tb_json_string_escaper_top: errors");
    $finish;
  end

endmodule

// File: json_string_escaper_top.f
rtl/jse_pkg.sv
rtl/jse_in_if.sv
rtl/jse_out_if.sv
rtl/jse_encoder.sv
rtl/json_string_escaper_top.sv
test/tb_json_string_escaper_top.sv
